FILE: sv/tpes_pkg.sv
`default_nettype none

package tpes_pkg;

  // Field and datapath widths
  localparam int unsigned RawW   = 16;
  localparam int unsigned OffW   = 17;
  localparam int unsigned ScaleW = 12;
  localparam int unsigned DiffW  = 18;  // raw - offset, signed
  localparam int unsigned MagW   = 17;  // |raw - offset|
  localparam int unsigned CoordW = 20;  // signed working width for clamping
  localparam int unsigned XW     = 9;
  localparam int unsigned YW     = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 17;

  // Default screen geometry
  localparam int unsigned DefScreenWidth  = 320;
  localparam int unsigned DefScreenHeight = 240;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgOffsetX = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgOffsetY = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgScaleX  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgScaleY  = 2'd3;

  // Pen event codes
  typedef enum logic [1:0] {
    EV_NONE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_HOLD    = 2'd2,
    EV_RELEASE = 2'd3
  } pen_event_e;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

FILE: sv/tpes_div.sv
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module tpes_div (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [tpes_pkg::MagW-1:0]         dividend_i,
  input  wire logic [tpes_pkg::ScaleW-1:0]       divisor_i,
  output tpes_pkg::div_stat_t                    stat_o,
  output logic      [tpes_pkg::MagW-1:0]         quotient_o
);

  localparam int unsigned CntW = $clog2(tpes_pkg::MagW + 1);

  logic [CntW-1:0]                cnt_q;
  logic                           busy_q;
  logic                           done_q;
  logic [tpes_pkg::MagW-1:0]      dvd_q;
  logic [tpes_pkg::ScaleW-1:0]    dsr_q;
  logic [tpes_pkg::ScaleW-1:0]    rem_q;
  logic [tpes_pkg::ScaleW-1:0]    rem_d;
  logic [tpes_pkg::ScaleW:0]      trial;
  logic [tpes_pkg::ScaleW:0]      trial_sub;
  logic                           ge;

  // Shift in next dividend bit and try a subtract
  always_comb begin
    trial     = {rem_q, dvd_q[tpes_pkg::MagW-1]};
    ge        = (trial >= {1'b0, dsr_q});
    trial_sub = trial - {1'b0, dsr_q};
    rem_d     = ge ? trial_sub[tpes_pkg::ScaleW-1:0] : trial[tpes_pkg::ScaleW-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CntW'(tpes_pkg::MagW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= {dvd_q[tpes_pkg::MagW-2:0], ge};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = dvd_q;

endmodule

`default_nettype wire

FILE: sv/touch_pen_event_and_scaling.sv
`default_nettype none

// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_ready_o   | pen_down_i, raw_x_i, raw_y_i
// out     | output    | out_valid_o / out_ready_i | screen_x_o, screen_y_o, pen_event_o
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// A pen-up sample (none or release) is answered in the cycle after acceptance from the held coordinates.
// A press or hold sample goes through setup and two runs of the shared serial divider
// (X then Y), each followed by a quotient capture and a clamp, then output.
// Reset clears state, pen level, last coordinates and registers (offsets 0, scales 1).
// A request is taken only when the sequencer is idle and the result register is free
// or being drained; a stalled result holds the block at its final step.
module touch_pen_event_and_scaling #(
  parameter int unsigned SCREEN_WIDTH  = tpes_pkg::DefScreenWidth,
  parameter int unsigned SCREEN_HEIGHT = tpes_pkg::DefScreenHeight
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic                            pen_down_i,
  input  wire logic [tpes_pkg::RawW-1:0]       raw_x_i,
  input  wire logic [tpes_pkg::RawW-1:0]       raw_y_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [tpes_pkg::XW-1:0]         screen_x_o,
  output logic      [tpes_pkg::YW-1:0]         screen_y_o,
  output logic      [1:0]                      pen_event_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [tpes_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [tpes_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned CW = tpes_pkg::CoordW;
  localparam logic signed [CW-1:0] XLim = CW'(SCREEN_WIDTH - 1);
  localparam logic signed [CW-1:0] YLim = CW'(SCREEN_HEIGHT - 1);
  localparam logic signed [CW-1:0] XTop = CW'(SCREEN_WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START_X,
    S_WAIT_X,
    S_CLAMP_X,
    S_WAIT_Y,
    S_CLAMP_Y,
    S_OUT
  } state_e;

  state_e                              state_q;
  logic                                prev_pen_q;
  logic [tpes_pkg::XW-1:0]             last_x_q;
  logic [tpes_pkg::YW-1:0]             last_y_q;
  tpes_pkg::pen_event_e                ev_q;
  logic                                out_valid_q;
  logic [tpes_pkg::XW-1:0]             out_x_q;
  logic [tpes_pkg::YW-1:0]             out_y_q;
  tpes_pkg::pen_event_e                out_ev_q;

  logic signed [tpes_pkg::OffW-1:0]    offset_x_q;
  logic signed [tpes_pkg::OffW-1:0]    offset_y_q;
  logic [tpes_pkg::ScaleW-1:0]         scale_x_q;
  logic [tpes_pkg::ScaleW-1:0]         scale_y_q;

  logic signed [tpes_pkg::DiffW-1:0]   diff_x_q;
  logic signed [tpes_pkg::DiffW-1:0]   diff_y_q;
  logic signed [tpes_pkg::DiffW-1:0]   quot_q;

  tpes_pkg::pen_event_e                ev_d;
  logic                                in_fire;
  logic                                out_free;
  logic                                touch_ev;
  logic signed [tpes_pkg::DiffW-1:0]   div_diff;
  logic signed [tpes_pkg::DiffW-1:0]   div_neg;
  logic [tpes_pkg::MagW-1:0]           div_mag;
  logic [tpes_pkg::ScaleW-1:0]         div_dsr;
  logic                                div_start;
  tpes_pkg::div_stat_t                 div_stat;
  logic [tpes_pkg::MagW-1:0]           div_quot;
  logic signed [tpes_pkg::DiffW-1:0]   quot_signed;
  logic signed [tpes_pkg::DiffW-1:0]   quot_neg;
  logic signed [CW-1:0]                quot_ext;
  logic signed [CW-1:0]                x_full;
  logic signed [CW-1:0]                x_sat;
  logic signed [CW-1:0]                y_sat;
  logic scale_zero;

  // Handshake
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Pen event from previous and current level
  always_comb begin
    unique case ({prev_pen_q, pen_down_i})
      2'b00:   ev_d = tpes_pkg::EV_NONE;
      2'b01:   ev_d = tpes_pkg::EV_PRESS;
      2'b11:   ev_d = tpes_pkg::EV_HOLD;
      default: ev_d = tpes_pkg::EV_RELEASE;
    endcase
    touch_ev = (ev_d == tpes_pkg::EV_PRESS) || (ev_d == tpes_pkg::EV_HOLD);
  end

  // Divider operand select: X in S_START_X, Y in S_CLAMP_X
  always_comb begin
    div_start = (state_q == S_START_X) || (state_q == S_CLAMP_X);
    div_diff  = (state_q == S_START_X) ? diff_x_q : diff_y_q;
    div_dsr   = (state_q == S_START_X) ? scale_x_q : scale_y_q;
    div_neg   = -div_diff;
    div_mag   = div_diff[tpes_pkg::DiffW-1] ? div_neg[tpes_pkg::MagW-1:0]
                                            : div_diff[tpes_pkg::MagW-1:0];
  end

  tpes_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_mag),
    .divisor_i  (div_dsr),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  // Restore sign of the quotient (truncation toward zero)
  always_comb begin
    quot_neg    = -signed'({1'b0, div_quot});
    quot_signed = ((state_q == S_WAIT_X) ? diff_x_q[tpes_pkg::DiffW-1]
                                         : diff_y_q[tpes_pkg::DiffW-1])
                  ? quot_neg : signed'({1'b0, div_quot});
  end

  // Mirror and saturate
  always_comb begin
    quot_ext = {{(CW - tpes_pkg::DiffW){quot_q[tpes_pkg::DiffW-1]}}, quot_q};
    x_full   = XTop - quot_ext;
    priority if (x_full < 0)    x_sat = '0;
    else if (x_full > XLim)     x_sat = XLim;
    else                        x_sat = x_full;
    priority if (quot_ext < 0)  y_sat = '0;
    else if (quot_ext > YLim)   y_sat = YLim;
    else                        y_sat = quot_ext;
  end

  // Configuration registers; a zero scale acts as one
  assign scale_zero = (cfg_data_i[tpes_pkg::ScaleW-1:0] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
      scale_x_q  <= tpes_pkg::ScaleW'(1);
      scale_y_q  <= tpes_pkg::ScaleW'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tpes_pkg::CfgOffsetX: offset_x_q <= signed'(cfg_data_i);
        tpes_pkg::CfgOffsetY: offset_y_q <= signed'(cfg_data_i);
        tpes_pkg::CfgScaleX:  scale_x_q  <= scale_zero ? tpes_pkg::ScaleW'(1)
                                                       : cfg_data_i[tpes_pkg::ScaleW-1:0];
        tpes_pkg::CfgScaleY:  scale_y_q  <= scale_zero ? tpes_pkg::ScaleW'(1)
                                                       : cfg_data_i[tpes_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  // Offset subtraction captured with the request
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      diff_x_q <= signed'({2'b00, raw_x_i}) -
                  {offset_x_q[tpes_pkg::OffW-1], offset_x_q};
      diff_y_q <= signed'({2'b00, raw_y_i}) -
                  {offset_y_q[tpes_pkg::OffW-1], offset_y_q};
    end
    if (div_stat.done) begin
      quot_q <= quot_signed;
    end
  end

  // Sequencer, held coordinates and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      prev_pen_q  <= 1'b0;
      last_x_q    <= '0;
      last_y_q    <= '0;
      ev_q        <= tpes_pkg::EV_NONE;
      out_valid_q <= 1'b0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_ev_q    <= tpes_pkg::EV_NONE;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            prev_pen_q <= pen_down_i;
            ev_q       <= ev_d;
            if (touch_ev) begin
              state_q <= S_START_X;
            end else begin
              out_valid_q <= 1'b1;
              out_x_q     <= last_x_q;
              out_y_q     <= last_y_q;
              out_ev_q    <= ev_d;
            end
          end
        end
        S_START_X: state_q <= S_WAIT_X;
        S_WAIT_X: begin
          if (div_stat.done) state_q <= S_CLAMP_X;
        end
        S_CLAMP_X: begin
          last_x_q <= x_sat[tpes_pkg::XW-1:0];
          state_q  <= S_WAIT_Y;
        end
        S_WAIT_Y: begin
          if (div_stat.done) state_q <= S_CLAMP_Y;
        end
        S_CLAMP_Y: begin
          last_y_q <= y_sat[tpes_pkg::YW-1:0];
          state_q  <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_x_q     <= last_x_q;
            out_y_q     <= last_y_q;
            out_ev_q    <= ev_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign screen_x_o  = out_x_q;
  assign screen_y_o  = out_y_q;
  assign pen_event_o = out_ev_q;

  // The divider only runs while the sequencer waits on it
  a_div_owned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> (state_q == S_WAIT_X) || (state_q == S_WAIT_Y))
    else $error("divider busy outside a wait state");

  // A pen-up request is answered on the next cycle with the held coordinates
  a_pen_up_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !touch_ev) |=> out_valid_o && (screen_x_o == $past(last_x_q))
                               && (screen_y_o == $past(last_y_q)))
    else $error("pen-up result not issued from held coordinates");

  // Emitted X never exceeds the right edge when the field can hold it
  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (SCREEN_WIDTH > (1 << tpes_pkg::XW)) ||
                    ({{(CW - tpes_pkg::XW){1'b0}}, screen_x_o} <= XLim))
    else $error("screen_x beyond screen width");

  // A touch result carries press or hold
  a_touch_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=>
      out_valid_o && ((pen_event_o == tpes_pkg::EV_PRESS) ||
                      (pen_event_o == tpes_pkg::EV_HOLD)))
    else $error("touch result with wrong pen event");

endmodule

`default_nettype wire

FILE: sim/tb_touch_pen_event_and_scaling.sv
`timescale 1ns / 1ps

module tb_touch_pen_event_and_scaling;

  localparam longint ScrW = tpes_pkg::DefScreenWidth;
  localparam longint ScrH = tpes_pkg::DefScreenHeight;
  localparam int CycleLimit = 500000;
  localparam int NumPhases = 11;
  localparam int PhaseSamples = 48;
  localparam int NumRows = 32;

  // Expected screen point for one touch sample
  typedef struct packed {
    logic [tpes_pkg::XW-1:0] x;
    logic [tpes_pkg::YW-1:0] y;
    tpes_pkg::pen_event_e    ev;
  } touch_pt_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_e;

  // Directed row: a sample (pen, raw_x in a, raw_y in b) or a register
  // write (data in a, index in b); typed rows carry their own expectation.
  typedef struct {
    row_kind_e  kind;
    logic       pen;
    logic [16:0] a;
    logic [15:0] b;
    logic       typed;
    touch_pt_t  want;
  } dir_row_t;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic                          pen_down_i;
  logic [tpes_pkg::RawW-1:0]     raw_x_i;
  logic [tpes_pkg::RawW-1:0]     raw_y_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic [tpes_pkg::XW-1:0]       screen_x_o;
  logic [tpes_pkg::YW-1:0]       screen_y_o;
  logic [1:0]                    pen_event_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [tpes_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [tpes_pkg::CfgDataW-1:0] cfg_data_i;

  // Predictor copy of calibration and pen state
  logic signed [16:0]      cal_off_x = '0;
  logic signed [16:0]      cal_off_y = '0;
  logic [11:0]             cal_scale_x = 12'd1;
  logic [11:0]             cal_scale_y = 12'd1;
  logic                    pen_prev = 1'b0;
  logic [tpes_pkg::XW-1:0] pt_last_x = '0;
  logic [tpes_pkg::YW-1:0] pt_last_y = '0;

  touch_pt_t pending_pts[$];
  logic      row_typed = 1'b0;
  touch_pt_t row_want = '0;
  int        fail_cnt = 0;
  int        cycle_cnt = 0;

  dir_row_t dir_rows [NumRows] = '{
    // reset calibration: pen level sequence and screen edges
    '{ROW_SAMPLE, 1'b0, 17'hFFFF, 16'hFFFF, 1'b1, '{9'd0, 8'd0, tpes_pkg::EV_NONE}},
    '{ROW_SAMPLE, 1'b1, 17'h0, 16'h0, 1'b1, '{9'd319, 8'd0, tpes_pkg::EV_PRESS}},
    '{ROW_SAMPLE, 1'b1, 17'hFFFF, 16'hFFFF, 1'b1, '{9'd0, 8'd239, tpes_pkg::EV_HOLD}},
    '{ROW_SAMPLE, 1'b1, 17'd100, 16'd100, 1'b1, '{9'd220, 8'd100, tpes_pkg::EV_HOLD}},
    '{ROW_SAMPLE, 1'b0, 17'h0, 16'h0, 1'b1, '{9'd220, 8'd100, tpes_pkg::EV_RELEASE}},
    '{ROW_SAMPLE, 1'b0, 17'hFFFF, 16'h0, 1'b1, '{9'd220, 8'd100, tpes_pkg::EV_NONE}},
    '{ROW_SAMPLE, 1'b1, 17'd320, 16'd240, 1'b1, '{9'd0, 8'd239, tpes_pkg::EV_PRESS}},
    '{ROW_SAMPLE, 1'b1, 17'd1, 16'd239, 1'b1, '{9'd319, 8'd239, tpes_pkg::EV_HOLD}},
    '{ROW_SAMPLE, 1'b1, 17'd319, 16'd0, 1'b1, '{9'd1, 8'd0, tpes_pkg::EV_HOLD}},
    // most negative / most positive offsets, zero scales
    '{ROW_CFG, 1'b0, 17'h10000, 16'(tpes_pkg::CfgOffsetX), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'h0FFFF, 16'(tpes_pkg::CfgOffsetY), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'h0, 16'(tpes_pkg::CfgScaleX), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'h0, 16'(tpes_pkg::CfgScaleY), 1'b0, '0},
    '{ROW_SAMPLE, 1'b1, 17'h0, 16'h0, 1'b1, '{9'd0, 8'd0, tpes_pkg::EV_HOLD}},
    '{ROW_SAMPLE, 1'b1, 17'hFFFF, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, 1'b0, 17'h0, 16'h0, 1'b0, '0},
    // opposite offsets, widest scales
    '{ROW_CFG, 1'b0, 17'h0FFFF, 16'(tpes_pkg::CfgOffsetX), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'h10000, 16'(tpes_pkg::CfgOffsetY), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'hFFF, 16'(tpes_pkg::CfgScaleX), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'hFFF, 16'(tpes_pkg::CfgScaleY), 1'b0, '0},
    '{ROW_SAMPLE, 1'b1, 17'h0, 16'h0, 1'b0, '0},
    '{ROW_SAMPLE, 1'b1, 17'hFFFF, 16'hFFFF, 1'b0, '0},
    '{ROW_SAMPLE, 1'b1, 17'h8000, 16'h7FFF, 1'b0, '0},
    // small scales, mixed-sign offsets: truncation and saturation
    '{ROW_CFG, 1'b0, 17'h1FF00, 16'(tpes_pkg::CfgOffsetX), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'd100, 16'(tpes_pkg::CfgOffsetY), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'd3, 16'(tpes_pkg::CfgScaleX), 1'b0, '0},
    '{ROW_CFG, 1'b0, 17'd7, 16'(tpes_pkg::CfgScaleY), 1'b0, '0},
    '{ROW_SAMPLE, 1'b1, 17'd1000, 16'd50, 1'b0, '0},
    '{ROW_SAMPLE, 1'b1, 17'd500, 16'd1000, 1'b0, '0},
    '{ROW_SAMPLE, 1'b1, 17'hAAAA, 16'h5555, 1'b0, '0},
    '{ROW_SAMPLE, 1'b0, 17'h5555, 16'hAAAA, 1'b0, '0},
    '{ROW_SAMPLE, 1'b0, 17'h0, 16'h0, 1'b0, '0}
  };

  touch_pen_event_and_scaling u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pen_down_i  (pen_down_i),
    .raw_x_i     (raw_x_i),
    .raw_y_i     (raw_y_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .screen_x_o  (screen_x_o),
    .screen_y_o  (screen_y_o),
    .pen_event_o (pen_event_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Signed quotient, truncated toward zero; a zero scale counts as one
  function automatic longint axis_quot(input logic [15:0] raw,
                                       input logic signed [16:0] off,
                                       input logic [11:0] scale);
    longint diff;
    longint div;
    diff = longint'(raw) - longint'(off);
    div = (scale == '0) ? 1 : longint'(scale);
    return diff / div;
  endfunction

  function automatic longint clamp_coord(input longint v, input longint lim);
    if (v < 0) return 0;
    if (v > lim - 1) return lim - 1;
    return v;
  endfunction

  // Classify the pen edge and map the raw words to screen pixels
  function automatic touch_pt_t track_sample(input logic pen, input logic [15:0] rx,
                                             input logic [15:0] ry);
    tpes_pkg::pen_event_e ev;
    longint               px;
    longint               py;
    if (!pen_prev) ev = pen ? tpes_pkg::EV_PRESS : tpes_pkg::EV_NONE;
    else ev = pen ? tpes_pkg::EV_HOLD : tpes_pkg::EV_RELEASE;
    pen_prev = pen;
    if (ev == tpes_pkg::EV_PRESS || ev == tpes_pkg::EV_HOLD) begin
      px = clamp_coord(ScrW - axis_quot(rx, cal_off_x, cal_scale_x), ScrW);
      py = clamp_coord(axis_quot(ry, cal_off_y, cal_scale_y), ScrH);
      pt_last_x = px[tpes_pkg::XW-1:0];
      pt_last_y = py[tpes_pkg::YW-1:0];
    end
    return '{pt_last_x, pt_last_y, ev};
  endfunction

  function automatic void apply_cal(input logic [tpes_pkg::CfgIdxW-1:0] idx,
                                    input logic [tpes_pkg::CfgDataW-1:0] data);
    case (idx)
      tpes_pkg::CfgOffsetX: cal_off_x = data;
      tpes_pkg::CfgOffsetY: cal_off_y = data;
      tpes_pkg::CfgScaleX:  cal_scale_x = data[11:0];
      tpes_pkg::CfgScaleY:  cal_scale_y = data[11:0];
      default: ;
    endcase
  endfunction

  // Monitor: predict on each accepted request, check each accepted result
  always @(posedge clk_i) begin
    touch_pt_t want;
    cycle_cnt++;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) apply_cal(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o) begin
        want = track_sample(pen_down_i, raw_x_i, raw_y_i);
        if (row_typed) want = row_want;
        pending_pts.push_back(want);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_pts.size() == 0) begin
          $error("unexpected result: screen_x %0d screen_y %0d pen_event %0d",
                 screen_x_o, screen_y_o, pen_event_o);
          fail_cnt++;
        end else begin
          want = pending_pts.pop_front();
          if (screen_x_o !== want.x) begin
            $error("screen_x: expected %0d, got %0d", want.x, screen_x_o);
            fail_cnt++;
          end
          if (screen_y_o !== want.y) begin
            $error("screen_y: expected %0d, got %0d", want.y, screen_y_o);
            fail_cnt++;
          end
          if (pen_event_o !== want.ev) begin
            $error("pen_event: expected %0d, got %0d", want.ev, pen_event_o);
            fail_cnt++;
          end
        end
      end
    end
  end

  // Result side stalls on its own changing pattern
  initial begin
    rx_mode_e mode;
    int       len;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      len = $urandom_range(8, 96);
      for (int i = 0; i < len; i++) begin
        @(negedge clk_i);
        case (mode)
          RX_ALWAYS: out_ready_i = 1'b1;
          RX_COIN:   out_ready_i = 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready_i = ($urandom_range(0, 4) == 0);
          default:   out_ready_i = (i % 12 >= 9);
        endcase
      end
    end
  end

  initial begin
    wait (cycle_cnt >= CycleLimit);
    $display("[touch_pen_event_and_scaling] ERROR");
    $finish;
  end

  // Present one sample request; valid stays high afterwards
  task automatic send_sample(input logic pen, input logic [15:0] rx, input logic [15:0] ry,
                             input logic typed, input touch_pt_t want);
    @(negedge clk_i);
    in_valid_i = 1'b1;
    pen_down_i = pen;
    raw_x_i = rx;
    raw_y_i = ry;
    row_typed = typed;
    row_want = want;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_pending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_pts.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [tpes_pkg::CfgIdxW-1:0] idx,
                           input logic [tpes_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic logic [16:0] rand_offset();
    case ($urandom_range(0, 5))
      0: return 17'h10000;
      1: return 17'h0FFFF;
      2: return '0;
      3: return 17'($urandom_range(0, 4000)) - 17'd2000;
      default: return 17'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_scale();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 17'd1;
      2: return 17'hFFF;
      3, 4: return 17'($urandom_range(1, 300));
      default: return 17'($urandom_range(0, 4095));
    endcase
  endfunction

  // Mostly raw words that land near the visible area for this calibration
  function automatic logic [15:0] pick_raw(input logic signed [16:0] off,
                                           input logic [11:0] scale, input int span);
    longint sc;
    longint v;
    int     k;
    sc = (scale == '0) ? 1 : longint'(scale);
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: begin
        k = int'($urandom_range(0, span + 10)) - 5;
        v = longint'(off) + longint'(k) * sc + longint'($urandom_range(0, int'(sc - 1)));
        if (v >= 0 && v <= 65535) return 16'(v);
        return 16'($urandom);
      end
    endcase
  endfunction

  initial begin
    int         burst_left;
    int         pen_left;
    int         gap;
    bit         steady;
    logic       pen_lvl;
    logic       pen;
    logic [15:0] rx;
    logic [15:0] ry;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pen_down_i = 1'b0;
    raw_x_i = '0;
    raw_y_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // Directed table
    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_CFG) begin
        drain_pending();
        write_reg(dir_rows[r].b[tpes_pkg::CfgIdxW-1:0], dir_rows[r].a);
      end else begin
        send_sample(dir_rows[r].pen, dir_rows[r].a[15:0], dir_rows[r].b,
                    dir_rows[r].typed, dir_rows[r].want);
      end
    end

    // Random phases, each under a fresh calibration
    pen_lvl = 1'b0;
    pen_left = 0;
    burst_left = $urandom_range(1, 12);
    for (int phase = 0; phase < NumPhases; phase++) begin
      drain_pending();
      write_reg(tpes_pkg::CfgOffsetX, rand_offset());
      write_reg(tpes_pkg::CfgOffsetY, rand_offset());
      write_reg(tpes_pkg::CfgScaleX, rand_scale());
      write_reg(tpes_pkg::CfgScaleY, rand_scale());
      steady = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PhaseSamples; n++) begin
        // pen strokes: runs of touch samples between short lifts, some noise
        if (pen_left == 0) begin
          pen_lvl = ~pen_lvl;
          pen_left = pen_lvl ? $urandom_range(1, 10) : $urandom_range(1, 3);
        end
        pen_left--;
        pen = ($urandom_range(0, 9) == 0) ? 1'($urandom) : pen_lvl;
        rx = pick_raw(cal_off_x, cal_scale_x, 330);
        ry = pick_raw(cal_off_y, cal_scale_y, 250);
        send_sample(pen, rx, ry, 1'b0, '0);

        if ($urandom_range(0, 49) == 0) begin
          drain_pending();
        end else if (--burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = steady ? 0 : $urandom_range(0, 6);
          if (gap > 0) begin
            @(negedge clk_i);
            in_valid_i = 1'b0;
            repeat (gap - 1) @(negedge clk_i);
          end
        end
      end
    end

    drain_pending();
    repeat (100) @(posedge clk_i);
    if (pending_pts.size() != 0) begin
      $error("%0d results never arrived", pending_pts.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) begin
      $display("[touch_pen_event_and_scaling] OK");
    end else begin
      $display("[touch_pen_event_and_scaling] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/tpes_pkg.sv
sv/tpes_div.sv
sv/touch_pen_event_and_scaling.sv
sim/tb_touch_pen_event_and_scaling.sv
